// ----- rtl/tmt_pkg.sv -----
// Shared types, constants and the sine table generator for the tube mesh tessellator.
package tmt_pkg;

  localparam int unsigned VERT_COUNT = 24;
  localparam logic [4:0]  LAST_VERT  = 5'(VERT_COUNT - 1);

  localparam logic [15:0] MIN_OUTER_RADIUS = 16'd41;
  localparam logic [15:0] MIN_INNER_RADIUS = 16'd20;
  localparam logic [15:0] MIN_TUBE_HEIGHT  = 16'd41;
  localparam logic [8:0]  MIN_SEGMENTS     = 9'd3;

  localparam logic [15:0] RESET_OUTER_RADIUS = 16'd4096;
  localparam logic [15:0] RESET_INNER_RADIUS = 16'd2048;
  localparam logic [15:0] RESET_TUBE_HEIGHT  = 16'd4096;
  localparam logic [8:0]  RESET_SEG_COUNT    = 9'd12;
  localparam logic [15:0] RESET_ANGLE_STEP   = 16'd5461;
  localparam logic [15:0] RESET_COLOR        = 16'd32768;

  // Q1.15 rounding bias for radius * sine products
  localparam logic [31:0] ROUND_HALF = 32'd16384;

  typedef enum logic [2:0] {
    REG_OUTER_RADIUS = 3'd0,
    REG_INNER_RADIUS = 3'd1,
    REG_TUBE_HEIGHT  = 3'd2,
    REG_SEG_COUNT    = 3'd3,
    REG_ANGLE_STEP   = 3'd4,
    REG_COLOR_RED    = 3'd5,
    REG_COLOR_GREEN  = 3'd6,
    REG_COLOR_BLUE   = 3'd7
  } cfg_reg_e;

  // Geometry, radii and height clamped; user keeps it stable while busy, not enforced
  typedef struct packed {
    logic [15:0] ro;
    logic [15:0] ri;
    logic [15:0] height;
    logic [15:0] step;
  } geom_t;

  // One vertex job handed from the sequencer to the vertex pipe
  typedef struct packed {
    logic [8:0] seg;
    logic       bad;
    logic       last_seg;
    logic [4:0] vtx;
  } job_t;

  // Corner code per vertex: bit0 end phase, bit1 outer ring, bit2 top face
  localparam logic [2:0] CORNER_ORDER [VERT_COUNT] = '{
    3'd0, 3'd1, 3'd2, 3'd2, 3'd1, 3'd3,
    3'd7, 3'd5, 3'd6, 3'd6, 3'd5, 3'd4,
    3'd6, 3'd2, 3'd7, 3'd7, 3'd2, 3'd3,
    3'd1, 3'd0, 3'd5, 3'd5, 3'd0, 3'd4
  };

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint Q15_SCALE   = 64'sd32768;
  localparam longint Q15_HALF    = 64'sd16384;
  localparam longint TAYLOR_DIV [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                        64'sd110, 64'sd156, 64'sd210};

  // Quarter-wave sine entry k of 2^qbits steps, Q1.15; elaboration only
  function automatic logic [15:0] sine_entry(int unsigned k, int unsigned qbits);
    longint x;
    longint term;
    longint sum;
    longint v;
    x = (HALF_PI_Q30 * longint'(k)) >>> qbits;
    term = x;
    sum = x;
    for (int n = 0; n < 7; n++) begin
      term = term * x / ONE_Q30;
      term = term * x / ONE_Q30;
      term = -term / TAYLOR_DIV[n];
      sum = sum + term;
    end
    if (sum < 0) sum = 0;
    v = (sum + Q15_HALF) / Q15_SCALE;
    if (v > Q15_SCALE) v = Q15_SCALE;
    return 16'(v);
  endfunction

endpackage

// ----- rtl/tmt_sine_rom.sv -----
// Dual-read quarter-wave sine ROM with registered outputs.
module tmt_sine_rom #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                         clk,
  input  logic                         adv,
  input  logic [SINE_TABLE_BITS-2:0]   sin_addr,
  input  logic [SINE_TABLE_BITS-2:0]   cos_addr,
  output logic [15:0]                  sin_q,
  output logic [15:0]                  cos_q
);

  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int DEPTH = (1 << QBITS) + 1;

  typedef logic [15:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < DEPTH; k++) begin
      r[k] = tmt_pkg::sine_entry(k, QBITS);
    end
    return r;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    if (adv) begin
      sin_q <= SINE_ROM[sin_addr];
      cos_q <= SINE_ROM[cos_addr];
    end
  end

endmodule

// ----- rtl/tmt_seq.sv -----
// Slice sequencer: takes segment indexes and issues 24 vertex jobs per slice.
module tmt_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [8:0]        in_segment_index,
  input  logic [8:0]        seg_count,
  output logic              job_valid,
  output tmt_pkg::job_t     job
);

  logic       valid_r;
  logic [4:0] vtx_r;
  logic [8:0] seg_r;
  logic       bad_r;
  logic       last_seg_r;
  logic       take;

  // Next slice may load on the cycle its predecessor issues vertex 23
  assign in_stall = !adv || (valid_r && (vtx_r != tmt_pkg::LAST_VERT));
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      vtx_r   <= '0;
    end else if (adv) begin
      if (take) begin
        valid_r <= 1'b1;
        vtx_r   <= '0;
      end else if (valid_r) begin
        if (vtx_r == tmt_pkg::LAST_VERT) begin
          valid_r <= 1'b0;
        end else begin
          vtx_r <= vtx_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seg_r      <= in_segment_index;
      bad_r      <= (in_segment_index >= seg_count);
      last_seg_r <= (({1'b0, in_segment_index} + 10'd1) == {1'b0, seg_count});
    end
  end

  assign job_valid    = valid_r;
  assign job.seg      = seg_r;
  assign job.bad      = bad_r;
  assign job.last_seg = last_seg_r;
  assign job.vtx      = vtx_r;

  a_vtx_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && adv && (vtx_r != tmt_pkg::LAST_VERT))
      |=> (valid_r && (vtx_r == $past(vtx_r) + 5'd1)))
    else $error("sequencer skipped or repeated a vertex");

  a_hold_when_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(valid_r) && $stable(vtx_r)))
    else $error("sequencer moved while pipeline frozen");

  a_slice_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && (vtx_r != tmt_pkg::LAST_VERT)) |=> ($stable(seg_r) && $stable(bad_r)))
    else $error("slice replaced before its last vertex");

endmodule

// ----- rtl/tmt_vertex_pipe.sv -----
// Vertex pipe: phase multiply, sine lookup, radius scaling and output register.
module tmt_vertex_pipe #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               job_valid,
  input  tmt_pkg::job_t      job,
  input  tmt_pkg::geom_t     geom,
  output logic               out_valid,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  output logic [4:0]         out_vertex_number,
  output logic               out_bad_index,
  output logic               out_last_vertex
);

  localparam int AW    = SINE_TABLE_BITS - 1;
  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam logic [AW-1:0] QLEN = AW'(1) << QBITS;

  // stage 1: phase
  logic        v1_r, bad1_r, outer1_r, top1_r, zero1_r;
  logic [4:0]  vtx1_r;
  logic [15:0] ph1_r;
  logic [2:0]  corner;
  logic [25:0] ph_prod;

  assign corner  = tmt_pkg::CORNER_ORDER[job.vtx];
  assign ph_prod = ({1'b0, job.seg} + {9'b0, corner[0]}) * geom.step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vtx1_r   <= job.vtx;
      bad1_r   <= job.bad;
      outer1_r <= corner[1];
      top1_r   <= corner[2];
      zero1_r  <= corner[0] && job.last_seg;  // last slice closes at phase zero
      ph1_r    <= ph_prod[15:0];
    end
  end

  // stage 2: quadrant fold and ROM read
  logic        v2_r, bad2_r, outer2_r, top2_r, sneg2_r, cneg2_r;
  logic [4:0]  vtx2_r;
  logic [15:0] phase;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]  squad, cquad;
  logic [AW-1:0] w, sin_addr, cos_addr;
  logic [15:0] sin_q, cos_q;

  assign phase    = zero1_r ? 16'd0 : ph1_r;
  assign idx      = phase[15 -: SINE_TABLE_BITS];
  assign squad    = idx[SINE_TABLE_BITS-1 -: 2];
  assign cquad    = squad + 2'd1;
  assign w        = {1'b0, idx[QBITS-1:0]};
  assign sin_addr = squad[0] ? (QLEN - w) : w;
  assign cos_addr = cquad[0] ? (QLEN - w) : w;

  tmt_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk      (clk),
    .adv      (adv),
    .sin_addr (sin_addr),
    .cos_addr (cos_addr),
    .sin_q    (sin_q),
    .cos_q    (cos_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vtx2_r   <= vtx1_r;
      bad2_r   <= bad1_r;
      outer2_r <= outer1_r;
      top2_r   <= top1_r;
      sneg2_r  <= squad[1];
      cneg2_r  <= cquad[1];
    end
  end

  // stage 3: radius times sine and cosine
  logic        v3_r, bad3_r, top3_r, sneg3_r, cneg3_r;
  logic [4:0]  vtx3_r;
  logic [31:0] px3_r, py3_r;
  logic [15:0] radius;

  assign radius = outer2_r ? geom.ro : geom.ri;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vtx3_r  <= vtx2_r;
      bad3_r  <= bad2_r;
      top3_r  <= top2_r;
      sneg3_r <= sneg2_r;
      cneg3_r <= cneg2_r;
      px3_r   <= {16'd0, radius} * {16'd0, sin_q};
      py3_r   <= {16'd0, radius} * {16'd0, cos_q};
    end
  end

  // stage 4: round, sign and output register
  logic [31:0]        rx, ry;
  logic [16:0]        mag_x, mag_y;
  logic signed [16:0] x_nxt, y_nxt, z_nxt;
  logic               out_valid_r;
  logic signed [16:0] pos_x_r, pos_y_r, pos_z_r;
  logic [4:0]         vtx_r;
  logic               bad_r;

  assign rx    = px3_r + tmt_pkg::ROUND_HALF;
  assign ry    = py3_r + tmt_pkg::ROUND_HALF;
  assign mag_x = {1'b0, rx[30:15]};
  assign mag_y = {1'b0, ry[30:15]};
  assign x_nxt = bad3_r ? '0 : (sneg3_r ? -$signed(mag_x) : $signed(mag_x));
  assign y_nxt = bad3_r ? '0 : (cneg3_r ? -$signed(mag_y) : $signed(mag_y));
  assign z_nxt = (bad3_r || !top3_r) ? '0 : $signed(17'd0 - {1'b0, geom.height});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x_r <= x_nxt;
      pos_y_r <= y_nxt;
      pos_z_r <= z_nxt;
      vtx_r   <= vtx3_r;
      bad_r   <= bad3_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pos_x         = pos_x_r;
  assign out_pos_y         = pos_y_r;
  assign out_pos_z         = pos_z_r;
  assign out_vertex_number = vtx_r;
  assign out_bad_index     = bad_r;
  assign out_last_vertex   = (vtx_r == tmt_pkg::LAST_VERT);

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && bad_r) |-> (pos_x_r == '0 && pos_y_r == '0 && pos_z_r == '0))
    else $error("bad slice carries a nonzero position");

  a_vtx_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && adv && (vtx_r != tmt_pkg::LAST_VERT))
      |=> (out_valid_r && (vtx_r == $past(vtx_r) + 5'd1)))
    else $error("vertex order broken within a slice");

  a_bad_per_slice: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && adv && (vtx_r != tmt_pkg::LAST_VERT)) |=> (bad_r == $past(bad_r)))
    else $error("bad flag changed within a slice");

endmodule

// ----- rtl/tube_mesh_tessellator.sv -----
// Top level of the tube mesh tessellator: config registers, clamping, sequencer and vertex pipe.
//
// Input channel: in_valid / in_stall with in_segment_index, one slice per transfer.
// Output channel: out_valid / out_stall, one vertex per transfer, 24 per slice in
// order, out_last_vertex marking the 24th. Config: cfg_we writes cfg_data to the
// register named by cfg_index; write only while the block is idle.
// Slices: the sequencer holds one slice at a time and the output channel is single-vertex;
// the next slice is taken on the cycle the current one issues its last vertex if
// the pipe is not frozen. Pipeline: a slice passes the sequencer register, then the
// phase multiply, sine ROM read, radius multiply and output register stages.
// Reset: synchronous, active low; empties the pipe and loads the default geometry
// (radius 1.0/0.5, height 1.0, 12 slices, white color).
// Stall: when out_stall is high with a vertex waiting, the whole pipe freezes,
// in_stall rises and nothing is dropped or repeated.
module tube_mesh_tessellator #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int MAX_SEGMENTS    = 360
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [8:0]         in_segment_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_pos_x,
  output logic signed [16:0] out_pos_y,
  output logic signed [16:0] out_pos_z,
  output logic [15:0]        out_vert_red,
  output logic [15:0]        out_vert_green,
  output logic [15:0]        out_vert_blue,
  output logic [4:0]         out_vertex_number,
  output logic               out_bad_index,
  output logic               out_last_vertex,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] outer_r, inner_r, height_r, step_r, red_r, green_r, blue_r;
  logic [8:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_r  <= tmt_pkg::RESET_OUTER_RADIUS;
      inner_r  <= tmt_pkg::RESET_INNER_RADIUS;
      height_r <= tmt_pkg::RESET_TUBE_HEIGHT;
      count_r  <= tmt_pkg::RESET_SEG_COUNT;
      step_r   <= tmt_pkg::RESET_ANGLE_STEP;
      red_r    <= tmt_pkg::RESET_COLOR;
      green_r  <= tmt_pkg::RESET_COLOR;
      blue_r   <= tmt_pkg::RESET_COLOR;
    end else if (cfg_we) begin
      unique case (tmt_pkg::cfg_reg_e'(cfg_index))
        tmt_pkg::REG_OUTER_RADIUS: outer_r  <= cfg_data;
        tmt_pkg::REG_INNER_RADIUS: inner_r  <= cfg_data;
        tmt_pkg::REG_TUBE_HEIGHT:  height_r <= cfg_data;
        tmt_pkg::REG_SEG_COUNT:    count_r  <= cfg_data[8:0];
        tmt_pkg::REG_ANGLE_STEP:   step_r   <= cfg_data;
        tmt_pkg::REG_COLOR_RED:    red_r    <= cfg_data;
        tmt_pkg::REG_COLOR_GREEN:  green_r  <= cfg_data;
        tmt_pkg::REG_COLOR_BLUE:   blue_r   <= cfg_data;
      endcase
    end
  end

  // Clamp, then swap radii if inner ends up larger
  logic [15:0] ro_c, ri_c;
  logic [8:0]  count_c;
  tmt_pkg::geom_t geom;

  assign ro_c = (outer_r < tmt_pkg::MIN_OUTER_RADIUS) ? tmt_pkg::MIN_OUTER_RADIUS : outer_r;
  assign ri_c = (inner_r < tmt_pkg::MIN_INNER_RADIUS) ? tmt_pkg::MIN_INNER_RADIUS : inner_r;
  assign geom.ro     = (ri_c > ro_c) ? ri_c : ro_c;
  assign geom.ri     = (ri_c > ro_c) ? ro_c : ri_c;
  assign geom.height = (height_r < tmt_pkg::MIN_TUBE_HEIGHT) ? tmt_pkg::MIN_TUBE_HEIGHT
                                                             : height_r;
  assign geom.step   = step_r;

  always_comb begin
    priority if (count_r < tmt_pkg::MIN_SEGMENTS) begin
      count_c = tmt_pkg::MIN_SEGMENTS;
    end else if (count_r > 9'(MAX_SEGMENTS)) begin
      count_c = 9'(MAX_SEGMENTS);
    end else begin
      count_c = count_r;
    end
  end

  logic          adv;
  logic          job_valid;
  tmt_pkg::job_t job;

  assign adv = !out_valid || !out_stall;

  tmt_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .adv              (adv),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_segment_index (in_segment_index),
    .seg_count        (count_c),
    .job_valid        (job_valid),
    .job              (job)
  );

  tmt_vertex_pipe #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_pipe (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .job_valid         (job_valid),
    .job               (job),
    .geom              (geom),
    .out_valid         (out_valid),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pos_z         (out_pos_z),
    .out_vertex_number (out_vertex_number),
    .out_bad_index     (out_bad_index),
    .out_last_vertex   (out_last_vertex)
  );

  // Colors come from config directly; user keeps them static while in flight, not enforced
  assign out_vert_red   = red_r;
  assign out_vert_green = green_r;
  assign out_vert_blue  = blue_r;

endmodule
